// ----- hdl/vfa_pkg.sv -----
// ----------------------------------------------------------------------------
// vfa_pkg
// Shared types, opcodes and helpers of the 2D fixed-point vector ALU.
// ----------------------------------------------------------------------------
package vfa_pkg;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_MULS  = 4'd4;
    localparam logic [3:0] OP_DIVS  = 4'd5;
    localparam logic [3:0] OP_DOT   = 4'd6;
    localparam logic [3:0] OP_LEN   = 4'd7;
    localparam logic [3:0] OP_NORM  = 4'd8;
    localparam logic [3:0] OP_NORMF = 4'd9;

    localparam logic [31:0] FIX_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] FIX_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] scalar_in;
    } t_req;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_scalar;
        logic               zero_guard;
        logic               overflow;
    } t_rsp;

    // Context carried alongside the square-root pipeline.
    typedef struct packed {
        t_req req;
        t_rsp early;
    } t_ctx;

    typedef struct packed {
        logic qneg;
        logic dzero;
        logic npos;
        logic nneg;
    } t_lane_flags;

    // Context carried alongside the divider lanes.
    typedef struct packed {
        logic [3:0]  op;
        t_rsp        early;
        logic [31:0] len;
        t_lane_flags fx;
        t_lane_flags fy;
    } t_dctx;

    // Saturate a wide signed value to 32 bits; the top bit is the overflow flag.
    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        logic [32:0] r;
        if (v > 66'sd2147483647) begin
            r = {1'b1, FIX_MAX};
        end else if (v < -66'sd2147483648) begin
            r = {1'b1, FIX_MIN};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

// ----- hdl/vfa_mul.sv -----
// ----------------------------------------------------------------------------
// vfa_mul
// One multiplier lane: a registered 32 x 32 signed product.
// ----------------------------------------------------------------------------
module vfa_mul (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_p
);
    logic signed [63:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;
endmodule

// ----- hdl/vfa_delay.sv -----
// ----------------------------------------------------------------------------
// vfa_delay
// Stallable shift line that keeps side information aligned with a pipeline.
// ----------------------------------------------------------------------------
module vfa_delay #(
    parameter int W = 8,
    parameter int D = 4
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_q [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int i = 1; i < D; i++) begin
                r_q[i] <= r_q[i-1];
            end
        end
    end

    assign o_q = r_q[D-1];
endmodule

// ----- hdl/vfa_sqrt.sv -----
// ----------------------------------------------------------------------------
// vfa_sqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module vfa_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_sq,
    output logic [31:0] o_root
);
    logic [63:0] r_rad  [32];
    logic [33:0] r_rem  [32];
    logic [31:0] r_root [32];

    for (genvar g = 0; g < 32; g++) begin : g_stage
        logic [63:0] in_rad;
        logic [33:0] in_rem;
        logic [31:0] in_root;
        logic [35:0] rem_n;
        logic [35:0] trial;
        logic [33:0] n_rem;
        logic [31:0] n_root;

        if (g == 0) begin : g_first
            assign in_rad  = i_sq;
            assign in_rem  = '0;
            assign in_root = '0;
        end else begin : g_next
            assign in_rad  = r_rad[g-1];
            assign in_rem  = r_rem[g-1];
            assign in_root = r_root[g-1];
        end

        always_comb begin
            rem_n = {in_rem, in_rad[63:62]};
            trial = {2'b00, in_root, 2'b01};
            if (rem_n >= trial) begin
                n_rem  = 34'(rem_n - trial);
                n_root = {in_root[30:0], 1'b1};
            end else begin
                n_rem  = rem_n[33:0];
                n_root = {in_root[30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[g]  <= {in_rad[61:0], 2'b00};
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
            end
        end
    end

    assign o_root = r_root[31];
endmodule

// ----- hdl/vfa_div.sv -----
// ----------------------------------------------------------------------------
// vfa_div
// Pipelined restoring divider lane, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vfa_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [32+FRAC_BITS-1:0] i_dividend,
    input  logic [31:0]             i_divisor,
    output logic [32+FRAC_BITS-1:0] o_quot
);
    localparam int QW = 32 + FRAC_BITS;

    logic [QW-1:0] r_dvd [QW];
    logic [31:0]   r_rem [QW];
    logic [31:0]   r_d   [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [QW-1:0] in_dvd;
        logic [31:0]   in_rem;
        logic [31:0]   in_d;
        logic [32:0]   rem_n;
        logic          ge;
        logic [31:0]   n_rem;

        if (g == 0) begin : g_first
            assign in_dvd = i_dividend;
            assign in_rem = '0;
            assign in_d   = i_divisor;
        end else begin : g_next
            assign in_dvd = r_dvd[g-1];
            assign in_rem = r_rem[g-1];
            assign in_d   = r_d[g-1];
        end

        always_comb begin
            rem_n = {in_rem, in_dvd[QW-1]};
            ge    = rem_n >= {1'b0, in_d};
            n_rem = ge ? 32'(rem_n - {1'b0, in_d}) : rem_n[31:0];
        end

        // Quotient bits shift in where the dividend bits leave.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dvd[g] <= {in_dvd[QW-2:0], ge};
                r_rem[g] <= n_rem;
                r_d[g]   <= in_d;
            end
        end
    end

    assign o_quot = r_dvd[QW-1];
endmodule

// ----- hdl/vec2_fixed_point_alu.sv -----
// Fixed-point format is Q16.16 at the default FRAC_BITS.
// Throughput: one transaction per cycle unless stalled; all opcodes run through the full
// pipeline of multiplier lanes, a 32-stage square root and 32 + FRAC_BITS divider stages.
// The whole pipeline advances unless the output register is held by i_stall.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// ----------------------------------------------------------------------------
// vec2_fixed_point_alu
// Stateless 2D vector ALU on signed fixed-point values with two parallel lanes.
// ----------------------------------------------------------------------------
module vec2_fixed_point_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  vfa_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output vfa_pkg::t_rsp o_rsp
);
    import vfa_pkg::*;

    localparam int QW  = 32 + FRAC_BITS;
    localparam int LAT = 37 + QW;
    localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic [QW-1:0] Q_MIN_MAG = QW'(33'h0_8000_0000);
    localparam logic [QW-1:0] Q_MAX_MAG = QW'(33'h0_7FFF_FFFF);

    logic           en;
    logic [LAT-1:0] r_vld;

    assign o_stall = r_vld[LAT-1] && i_stall;
    assign en      = !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Input register and multiplier operand selection.
    t_req r_a;
    t_req r_m;
    logic signed [31:0] mx_b;
    logic signed [31:0] my_b;
    logic signed [63:0] px;
    logic signed [63:0] py;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= i_req;
            r_m <= r_a;
        end
    end

    always_comb begin
        if (r_a.req_type == OP_MULS) begin
            mx_b = r_a.scalar_in;
            my_b = r_a.scalar_in;
        end else if (r_a.req_type inside {OP_LEN, OP_NORM}) begin
            mx_b = r_a.a_x;
            my_b = r_a.a_y;
        end else begin
            mx_b = r_a.b_x;
            my_b = r_a.b_y;
        end
    end

    vfa_mul u_mul_x (.i_clk(i_clk), .i_en(en), .i_a(r_a.a_x), .i_b(mx_b), .o_p(px));
    vfa_mul u_mul_y (.i_clk(i_clk), .i_en(en), .i_a(r_a.a_y), .i_b(my_b), .o_p(py));

    // Results that need no square root or division are settled here.
    logic signed [65:0] ex_ax, ex_ay, ex_bx, ex_by, ex_px, ex_py;
    logic signed [65:0] rnd_x, rnd_y, rnd_dot;
    logic [32:0]        sx, sy, ss;
    t_rsp               n_early;
    t_ctx               r_b_ctx;
    logic [63:0]        r_b_sq;

    always_comb begin
        ex_ax   = {{34{r_m.a_x[31]}}, r_m.a_x};
        ex_ay   = {{34{r_m.a_y[31]}}, r_m.a_y};
        ex_bx   = {{34{r_m.b_x[31]}}, r_m.b_x};
        ex_by   = {{34{r_m.b_y[31]}}, r_m.b_y};
        ex_px   = {{2{px[63]}}, px};
        ex_py   = {{2{py[63]}}, py};
        rnd_x   = (ex_px + HALF) >>> FRAC_BITS;
        rnd_y   = (ex_py + HALF) >>> FRAC_BITS;
        rnd_dot = (ex_px + ex_py + HALF) >>> FRAC_BITS;
        n_early = '0;
        sx      = '0;
        sy      = '0;
        ss      = '0;
        case (r_m.req_type)
            OP_ADD: begin
                sx = sat32(ex_ax + ex_bx);
                sy = sat32(ex_ay + ex_by);
            end
            OP_SUB: begin
                sx = sat32(ex_ax - ex_bx);
                sy = sat32(ex_ay - ex_by);
            end
            OP_MUL, OP_MULS: begin
                sx = sat32(rnd_x);
                sy = sat32(rnd_y);
            end
            OP_DOT: begin
                ss = sat32(rnd_dot);
            end
            default: begin
            end
        endcase
        n_early.out_x      = sx[31:0];
        n_early.out_y      = sy[31:0];
        n_early.out_scalar = ss[31:0];
        n_early.overflow   = sx[32] | sy[32] | ss[32];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_ctx.req   <= r_m;
            r_b_ctx.early <= n_early;
            r_b_sq        <= 64'(px) + 64'(py);
        end
    end

    // Square root of a_x^2 + a_y^2 with its context alongside.
    logic [31:0]          root;
    logic [$bits(t_ctx)-1:0] sq_ctx_bits;
    t_ctx                 sq_ctx;

    vfa_sqrt u_sqrt (.i_clk(i_clk), .i_en(en), .i_sq(r_b_sq), .o_root(root));

    vfa_delay #(.W($bits(t_ctx)), .D(32)) u_sq_ctx (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_b_ctx),
        .o_q   (sq_ctx_bits)
    );
    assign sq_ctx = t_ctx'(sq_ctx_bits);

    // Divider operand preparation: magnitudes and signs per lane.
    logic signed [31:0] dsx, dsy;
    logic               dnx, dny, nnx, nny;
    logic [31:0]        dmx, dmy, nmx, nmy;
    t_dctx              n_dctx;
    t_dctx              r_c_dctx;
    logic [QW-1:0]      r_c_nx, r_c_ny;
    logic [31:0]        r_c_dx, r_c_dy;

    always_comb begin
        dsx = sq_ctx.req.b_x;
        dsy = sq_ctx.req.b_y;
        if (sq_ctx.req.req_type inside {OP_DIVS, OP_NORMF}) begin
            dsx = sq_ctx.req.scalar_in;
            dsy = sq_ctx.req.scalar_in;
        end
        dnx = dsx[31];
        dny = dsy[31];
        dmx = dnx ? 32'(-dsx) : dsx;
        dmy = dny ? 32'(-dsy) : dsy;
        if (sq_ctx.req.req_type == OP_NORM) begin
            dnx = 1'b0;
            dny = 1'b0;
            dmx = root;
            dmy = root;
        end
        nnx = sq_ctx.req.a_x[31];
        nny = sq_ctx.req.a_y[31];
        nmx = nnx ? 32'(-sq_ctx.req.a_x) : sq_ctx.req.a_x;
        nmy = nny ? 32'(-sq_ctx.req.a_y) : sq_ctx.req.a_y;

        n_dctx.op       = sq_ctx.req.req_type;
        n_dctx.early    = sq_ctx.early;
        n_dctx.len      = root;
        n_dctx.fx.qneg  = nnx ^ dnx;
        n_dctx.fx.dzero = dmx == '0;
        n_dctx.fx.npos  = !nnx && nmx != '0;
        n_dctx.fx.nneg  = nnx;
        n_dctx.fy.qneg  = nny ^ dny;
        n_dctx.fy.dzero = dmy == '0;
        n_dctx.fy.npos  = !nny && nmy != '0;
        n_dctx.fy.nneg  = nny;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_dctx <= n_dctx;
            r_c_nx   <= {nmx, {FRAC_BITS{1'b0}}};
            r_c_ny   <= {nmy, {FRAC_BITS{1'b0}}};
            r_c_dx   <= dmx;
            r_c_dy   <= dmy;
        end
    end

    // Two divider lanes and the aligned context.
    logic [QW-1:0]            qx, qy;
    logic [$bits(t_dctx)-1:0] dv_ctx_bits;
    t_dctx                    dv_ctx;

    vfa_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r_c_nx),
        .i_divisor  (r_c_dx),
        .o_quot     (qx)
    );

    vfa_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r_c_ny),
        .i_divisor  (r_c_dy),
        .o_quot     (qy)
    );

    vfa_delay #(.W($bits(t_dctx)), .D(QW)) u_dv_ctx (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_c_dctx),
        .o_q   (dv_ctx_bits)
    );
    assign dv_ctx = t_dctx'(dv_ctx_bits);

    // Apply the quotient sign and saturate; the top bit is the overflow flag.
    function automatic logic [32:0] q_to_fix(input logic [QW-1:0] q, input logic neg);
        logic [32:0] r;
        logic [QW-1:0] nq;
        nq = -q;
        if (neg) begin
            if (q > Q_MIN_MAG) begin
                r = {1'b1, FIX_MIN};
            end else begin
                r = {1'b0, nq[31:0]};
            end
        end else if (q > Q_MAX_MAG) begin
            r = {1'b1, FIX_MAX};
        end else begin
            r = {1'b0, q[31:0]};
        end
        return r;
    endfunction

    // Merge the lanes into one result.
    logic [32:0] fx, fy;
    t_rsp        n_rsp;
    t_rsp        r_rsp;

    always_comb begin
        fx    = q_to_fix(qx, dv_ctx.fx.qneg);
        fy    = q_to_fix(qy, dv_ctx.fy.qneg);
        n_rsp = '0;
        case (dv_ctx.op)
            OP_ADD, OP_SUB, OP_MUL, OP_MULS, OP_DOT: begin
                n_rsp = dv_ctx.early;
            end
            OP_LEN: begin
                n_rsp.out_scalar = dv_ctx.len[31] ? FIX_MAX : dv_ctx.len;
                n_rsp.overflow   = dv_ctx.len[31];
            end
            OP_DIV: begin
                // Division by zero saturates toward the sign of the dividend.
                if (dv_ctx.fx.dzero) begin
                    fx = {1'b1, dv_ctx.fx.npos ? FIX_MAX : (dv_ctx.fx.nneg ? FIX_MIN : 32'd0)};
                end
                if (dv_ctx.fy.dzero) begin
                    fy = {1'b1, dv_ctx.fy.npos ? FIX_MAX : (dv_ctx.fy.nneg ? FIX_MIN : 32'd0)};
                end
                n_rsp.out_x    = fx[31:0];
                n_rsp.out_y    = fy[31:0];
                n_rsp.overflow = fx[32] | fy[32];
            end
            OP_DIVS, OP_NORMF, OP_NORM: begin
                if (dv_ctx.fx.dzero) begin
                    n_rsp.zero_guard = 1'b1;
                end else begin
                    n_rsp.out_x    = fx[31:0];
                    n_rsp.out_y    = fy[31:0];
                    n_rsp.overflow = fx[32] | fy[32];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_rsp   = r_rsp;

    a_guard_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.zero_guard |-> o_rsp.out_x == '0 && o_rsp.out_y == '0)
        else $error("zero guard with a nonzero vector");

    a_guard_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_rsp.zero_guard && o_rsp.overflow))
        else $error("zero guard and overflow together");

    a_scalar_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.out_scalar != '0 |-> o_rsp.out_x == '0 && o_rsp.out_y == '0)
        else $error("scalar and vector result together");

endmodule

// ----- dv/vfa_checker.sv -----
// ----------------------------------------------------------------------------
// vfa_checker
// Watches both channels of the vector ALU, predicts each response and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module vfa_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_stall,
    input  vfa_pkg::t_req i_req,
    input  logic          i_rsp_valid,
    input  logic          i_rsp_stall,
    input  vfa_pkg::t_rsp i_rsp,
    output int            o_fail_count,
    output int            o_pending
);
    import vfa_pkg::*;

    t_rsp expected_q[$];
    int   fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_q.size();

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                   inout logic ov);
        if (v > 128'sd2147483647) begin
            ov = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -128'sd2147483648) begin
            ov = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Arithmetic shift floors; adding half first gives ties toward plus infinity.
    function automatic logic signed [127:0] round_fix(input logic signed [127:0] p);
        logic signed [127:0] half;
        half = 128'sd1 <<< (FRAC_BITS - 1);
        return (p + half) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [127:0] quot_fix(input logic signed [127:0] num,
                                                     input logic signed [127:0] den);
        return (num <<< FRAC_BITS) / den;
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_rsp compute_vector(input t_req q);
        t_rsp r;
        logic signed [127:0] ax, ay, bx, by, s, len;
        logic ov;
        ax = q.a_x; ay = q.a_y; bx = q.b_x; by = q.b_y; s = q.scalar_in;
        r  = '0;
        ov = 1'b0;
        case (q.req_type)
            OP_ADD: begin
                r.out_x = clamp32(ax + bx, ov);
                r.out_y = clamp32(ay + by, ov);
            end
            OP_SUB: begin
                r.out_x = clamp32(ax - bx, ov);
                r.out_y = clamp32(ay - by, ov);
            end
            OP_MUL: begin
                r.out_x = clamp32(round_fix(ax * bx), ov);
                r.out_y = clamp32(round_fix(ay * by), ov);
            end
            OP_DIV: begin
                // Division by zero saturates toward the sign of the dividend.
                if (bx == 0) begin
                    ov = 1'b1;
                    r.out_x = ax > 0 ? 32'sh7FFF_FFFF : (ax < 0 ? 32'sh8000_0000 : 0);
                end else begin
                    r.out_x = clamp32(quot_fix(ax, bx), ov);
                end
                if (by == 0) begin
                    ov = 1'b1;
                    r.out_y = ay > 0 ? 32'sh7FFF_FFFF : (ay < 0 ? 32'sh8000_0000 : 0);
                end else begin
                    r.out_y = clamp32(quot_fix(ay, by), ov);
                end
            end
            OP_MULS: begin
                r.out_x = clamp32(round_fix(ax * s), ov);
                r.out_y = clamp32(round_fix(ay * s), ov);
            end
            OP_DIVS, OP_NORMF: begin
                if (s == 0) begin
                    r.zero_guard = 1'b1;
                end else begin
                    r.out_x = clamp32(quot_fix(ax, s), ov);
                    r.out_y = clamp32(quot_fix(ay, s), ov);
                end
            end
            OP_DOT: r.out_scalar = clamp32(round_fix(ax * bx + ay * by), ov);
            OP_LEN: begin
                len = root_floor(64'(ax * ax + ay * ay));
                r.out_scalar = clamp32(len, ov);
            end
            OP_NORM: begin
                len = root_floor(64'(ax * ax + ay * ay));
                if (len == 0) begin
                    r.zero_guard = 1'b1;
                end else begin
                    r.out_x = clamp32(quot_fix(ax, len), ov);
                    r.out_y = clamp32(quot_fix(ay, len), ov);
                end
            end
            default: ;
        endcase
        r.overflow = ov;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (i_req_valid && !i_req_stall) expected_q.push_back(compute_vector(i_req));
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected transaction", 32'(i_rsp.out_x), 0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_rsp.out_x !== want.out_x)
                        report_mismatch("out_x", i_rsp.out_x, want.out_x);
                    if (i_rsp.out_y !== want.out_y)
                        report_mismatch("out_y", i_rsp.out_y, want.out_y);
                    if (i_rsp.out_scalar !== want.out_scalar)
                        report_mismatch("out_scalar", i_rsp.out_scalar, want.out_scalar);
                    if (i_rsp.zero_guard !== want.zero_guard)
                        report_mismatch("zero_guard", 32'(i_rsp.zero_guard),
                                        32'(want.zero_guard));
                    if (i_rsp.overflow !== want.overflow)
                        report_mismatch("overflow", 32'(i_rsp.overflow),
                                        32'(want.overflow));
                end
            end
        end
    end

endmodule

// ----- dv/tb_vec2_fixed_point_alu.sv -----
// ----------------------------------------------------------------------------
// tb_vec2_fixed_point_alu
// Drives directed corner cases and random vector operations into the ALU
// with random idling and back pressure; a checker module scores responses.
// ----------------------------------------------------------------------------
module tb_vec2_fixed_point_alu;
    import vfa_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int LATENCY      = 69 + FRAC_BITS;
    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall;
    t_rsp o_rsp;
    int   fail_count;
    int   pending;
    int   cycles;
    logic quiet;       // no idling on either side
    logic hold_off;    // long receiver stall

    vec2_fixed_point_alu #(.FRAC_BITS(FRAC_BITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp)
    );

    vfa_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_valid), .i_req_stall(o_stall), .i_req(i_req),
        .i_rsp_valid(o_valid), .i_rsp_stall(i_stall), .i_rsp(o_rsp),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Receiver stall: random, except in quiet stretches and long hold-offs.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) i_stall <= 1'b1;
            else if (quiet) i_stall <= 1'b0;
            else i_stall <= ($urandom_range(99) < 29);
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'h0001_0000;
            4: return 32'hFFFF_0000;
            5: return $urandom_range(255) - 128;
            6: return 32'($signed(32'($urandom_range(65535))) - 32768) <<< 8;
            default: return $urandom;
        endcase
    endfunction

    // Valid stays high after acceptance so that the next transaction can
    // follow in the very next cycle; idling drops it.
    task automatic send_req(input t_req q);
        @(negedge i_clk);
        if (!quiet) begin
            while ($urandom_range(99) < 29) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_req   <= q;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_vector_op(input logic [3:0] op, input logic [31:0] ax,
                                  input logic [31:0] ay, input logic [31:0] bx,
                                  input logic [31:0] by, input logic [31:0] s);
        t_req q;
        q.req_type = op; q.a_x = ax; q.a_y = ay; q.b_x = bx; q.b_y = by;
        q.scalar_in = s;
        send_req(q);
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        t_req q;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_req    = '0;
        quiet    = 1'b0;
        hold_off = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, every opcode, zero divisors and zero lengths.
        send_vector_op(OP_ADD, FIX_MAX, FIX_MIN, 32'd1, 32'hFFFF_FFFF, 0);
        send_vector_op(OP_SUB, FIX_MIN, FIX_MAX, 32'd1, 32'hFFFF_FFFF, 0);
        send_vector_op(OP_MUL, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN, 0);
        send_vector_op(OP_MUL, 32'h0000_8000, 32'hFFFF_8000, 32'd1, 32'd1, 0);
        send_vector_op(OP_DIV, FIX_MAX, FIX_MIN, 32'd0, 32'd0, 0);
        send_vector_op(OP_DIV, 32'd0, FIX_MIN, 32'd0, 32'hFFFF_FFFF, 0);
        send_vector_op(OP_MULS, FIX_MAX, FIX_MIN, 0, 0, FIX_MIN);
        send_vector_op(OP_DIVS, 32'h0003_0000, FIX_MIN, 0, 0, 32'd0);
        send_vector_op(OP_DIVS, FIX_MAX, FIX_MIN, 0, 0, 32'd1);
        send_vector_op(OP_DOT, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, 0);
        send_vector_op(OP_DOT, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MAX, 0);
        send_vector_op(OP_LEN, FIX_MIN, FIX_MIN, 0, 0, 0);
        send_vector_op(OP_LEN, 0, 0, 0, 0, 0);
        send_vector_op(OP_NORM, 0, 0, 0, 0, 0);
        send_vector_op(OP_NORM, FIX_MIN, 32'd1, 0, 0, 0);
        send_vector_op(OP_NORM, 32'd3, 32'd4, 0, 0, 0);
        send_vector_op(OP_NORMF, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 32'd0);
        send_vector_op(OP_NORMF, FIX_MIN, FIX_MAX, 0, 0, 32'hFFFF_FFFF);
        send_vector_op(4'd10, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX);
        send_vector_op(4'd15, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN);

        // The sender pauses until every response has come.
        wait_drain();

        // Long receiver hold-off while the sender keeps offering.
        fork
            begin
                @(negedge i_clk);
                hold_off = 1'b1;
                repeat (3 * LATENCY) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 150; i++) begin
                q.req_type  = 4'($urandom);
                q.a_x       = $urandom;
                q.a_y       = $urandom;
                q.b_x       = $urandom;
                q.b_y       = $urandom;
                q.scalar_in = $urandom;
                send_req(q);
            end
        join

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet = (i >= 600 && i < 900);
            // Mostly valid opcodes; the rest are unused codes.
            q.req_type  = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 10))
                                                   : 4'($urandom_range(9));
            q.a_x       = pick_value();
            q.a_y       = pick_value();
            q.b_x       = pick_value();
            q.b_y       = pick_value();
            q.scalar_in = pick_value();
            send_req(q);
        end
        quiet = 1'b0;

        wait_drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
